// File: rtl/sqnf_pkg.sv
// ----------------------------------------------------------------------------
// sqnf_pkg
// Shared types and constants for the signed queue with negative filter.
// ----------------------------------------------------------------------------
package sqnf_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int WORD_W      = 32;
   localparam int OP_W        = 3;
   localparam int COUNT_W     = 5;
   localparam int STATUS_W    = 2;

   localparam logic [WORD_W-1:0] WORD_ALL_ONES = '1;

   typedef enum logic [OP_W-1:0] {
      OP_ENQUEUE    = 3'd0,
      OP_DEQUEUE    = 3'd1,
      OP_INSERT     = 3'd2,
      OP_REMOVE_NEG = 3'd3,
      OP_COUNT      = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHIFT,
      CELL_SWAP
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type mode;
      logic          phase;
   } cell_ctl_type;

   typedef struct packed {
      logic              drop;
      logic [WORD_W-1:0] data;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_SORT,
      ST_DONE
   } state_type;

endpackage

// File: rtl/sqnf_cell.sv
// ----------------------------------------------------------------------------
// sqnf_cell
// One queue slot: holds a word, shifts toward the head, or swaps with a
// neighbor during odd-even compaction.
// ----------------------------------------------------------------------------
module sqnf_cell #(
   parameter int DEPTH      = sqnf_pkg::QUEUE_DEPTH,
   parameter int CELL_INDEX = 0
) (
   input  logic                  clock,
   input  sqnf_pkg::cell_ctl_type ctl,
   input  sqnf_pkg::entry_type   left,
   input  sqnf_pkg::entry_type   right,
   output sqnf_pkg::entry_type   entry
);

   localparam logic PARITY    = 1'(CELL_INDEX % 2);
   localparam logic HAS_RIGHT = (CELL_INDEX < DEPTH - 1);
   localparam logic HAS_LEFT  = (CELL_INDEX > 0);

   sqnf_pkg::entry_type entry_ff;
   sqnf_pkg::entry_type entry_in;
   logic                pair_right;
   logic                pair_left;

   assign pair_right = (ctl.phase == PARITY) && HAS_RIGHT;
   assign pair_left  = (ctl.phase != PARITY) && HAS_LEFT;

   always_comb begin
      entry_in = entry_ff;
      case (ctl.mode)
         sqnf_pkg::CELL_SHIFT: begin
            entry_in = right;
         end
         sqnf_pkg::CELL_SWAP: begin
            if (pair_right && entry_ff.drop && !right.drop) begin
               entry_in = right;
            end else if (pair_left && left.drop && !entry_ff.drop) begin
               entry_in = left;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// File: rtl/sqnf_ctrl.sv
// ----------------------------------------------------------------------------
// sqnf_ctrl
// Sequencer for the cell chain: streams the head word back into the tail,
// runs the compaction rounds and holds the result word.
// ----------------------------------------------------------------------------
module sqnf_ctrl #(
   parameter int DEPTH = sqnf_pkg::QUEUE_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [sqnf_pkg::OP_W-1:0]             req_op,
   input  logic signed [sqnf_pkg::WORD_W-1:0]    req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [sqnf_pkg::WORD_W-1:0]    rsp_popped_value,
   output logic [sqnf_pkg::COUNT_W-1:0]          rsp_match_count,
   output logic [sqnf_pkg::STATUS_W-1:0]         rsp_status,
   output logic [sqnf_pkg::COUNT_W-1:0]          rsp_fill_level,
   input  sqnf_pkg::entry_type                   head,
   output sqnf_pkg::entry_type                   feed,
   output sqnf_pkg::cell_ctl_type                cell_ctl
);

   localparam int             CW       = $clog2(DEPTH + 1);
   localparam logic [CW-1:0]  LAST     = CW'(DEPTH - 1);
   localparam logic [CW-1:0]  FULL_CNT = CW'(DEPTH);
   localparam logic [CW-1:0]  ONE      = CW'(1);
   localparam int             MSB      = sqnf_pkg::WORD_W - 1;

   sqnf_pkg::state_type  state_ff, state_in;
   sqnf_pkg::op_type     op_ff, op_in;
   sqnf_pkg::status_type res_status_ff, res_status_in;
   logic [MSB:0]         val_ff, val_in;
   logic [MSB:0]         hold_ff, hold_in;
   logic [MSB:0]         res_popped_ff, res_popped_in;
   logic [CW-1:0]        k_ff, k_in;
   logic [CW-1:0]        acc_ff, acc_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 done_ins_ff, done_ins_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [MSB:0]         rsp_popped_ff, rsp_popped_in;
   logic [sqnf_pkg::COUNT_W-1:0]  rsp_match_ff, rsp_match_in;
   logic [sqnf_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [sqnf_pkg::COUNT_W-1:0]  rsp_fill_ff, rsp_fill_in;
   logic                 in_range;
   logic                 take_new;
   sqnf_pkg::op_type     req_code;

   assign req_code = sqnf_pkg::op_type'(req_op);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      res_status_in = res_status_ff;
      val_in        = val_ff;
      hold_in       = hold_ff;
      res_popped_in = res_popped_ff;
      k_in          = k_ff;
      acc_in        = acc_ff;
      cnt_in        = cnt_ff;
      done_ins_in   = done_ins_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_popped_in = rsp_popped_ff;
      rsp_match_in  = rsp_match_ff;
      rsp_status_in = rsp_status_ff;
      rsp_fill_in   = rsp_fill_ff;
      req_stall     = (state_ff != sqnf_pkg::ST_IDLE);
      cell_ctl.mode  = sqnf_pkg::CELL_HOLD;
      cell_ctl.phase = k_ff[0];
      feed.drop     = 1'b0;
      feed.data     = head.data;
      in_range      = (k_ff < cnt_ff);
      take_new      = 1'b0;

      case (state_ff)
         sqnf_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in         = req_code;
               val_in        = req_value;
               k_in          = '0;
               acc_in        = '0;
               done_ins_in   = 1'b0;
               res_popped_in = '0;
               res_status_in = sqnf_pkg::STATUS_OK;
               case (req_code)
                  sqnf_pkg::OP_ENQUEUE, sqnf_pkg::OP_INSERT: begin
                     if (cnt_ff == FULL_CNT) begin
                        res_status_in = sqnf_pkg::STATUS_FULL;
                        state_in      = sqnf_pkg::ST_DONE;
                     end else begin
                        state_in = sqnf_pkg::ST_ROTATE;
                     end
                  end
                  sqnf_pkg::OP_DEQUEUE: begin
                     if (cnt_ff == '0) begin
                        res_popped_in = sqnf_pkg::WORD_ALL_ONES;
                        res_status_in = sqnf_pkg::STATUS_EMPTY;
                     end else begin
                        res_popped_in = head.data;
                        cell_ctl.mode = sqnf_pkg::CELL_SHIFT;
                        cnt_in        = cnt_ff - ONE;
                     end
                     state_in = sqnf_pkg::ST_DONE;
                  end
                  sqnf_pkg::OP_REMOVE_NEG, sqnf_pkg::OP_COUNT: begin
                     state_in = sqnf_pkg::ST_ROTATE;
                  end
                  default: begin
                     state_in = sqnf_pkg::ST_DONE;
                  end
               endcase
            end
         end

         sqnf_pkg::ST_ROTATE: begin
            cell_ctl.mode = sqnf_pkg::CELL_SHIFT;
            k_in          = k_ff + ONE;
            case (op_ff)
               sqnf_pkg::OP_ENQUEUE, sqnf_pkg::OP_INSERT: begin
                  take_new = !done_ins_ff && ((k_ff == cnt_ff) ||
                             ((op_ff == sqnf_pkg::OP_INSERT) && in_range && head.data[MSB]));
                  if (take_new) begin
                     feed.data = val_ff;
                  end else if (done_ins_ff) begin
                     feed.data = hold_ff;
                  end
                  if (take_new || done_ins_ff) begin
                     hold_in = head.data;
                  end
                  done_ins_in = done_ins_ff | take_new;
               end
               sqnf_pkg::OP_REMOVE_NEG: begin
                  feed.drop = !in_range || head.data[MSB];
                  if (in_range && !head.data[MSB]) begin
                     acc_in = acc_ff + ONE;
                  end
               end
               sqnf_pkg::OP_COUNT: begin
                  if (in_range && (head.data == val_ff)) begin
                     acc_in = acc_ff + ONE;
                  end
               end
               default: begin
                  feed.drop = 1'b0;
               end
            endcase
            if (k_ff == LAST) begin
               k_in = '0;
               case (op_ff)
                  sqnf_pkg::OP_ENQUEUE, sqnf_pkg::OP_INSERT: begin
                     cnt_in   = cnt_ff + ONE;
                     state_in = sqnf_pkg::ST_DONE;
                  end
                  sqnf_pkg::OP_REMOVE_NEG: begin
                     cnt_in   = acc_in;
                     state_in = sqnf_pkg::ST_SORT;
                  end
                  default: begin
                     state_in = sqnf_pkg::ST_DONE;
                  end
               endcase
            end
         end

         sqnf_pkg::ST_SORT: begin
            cell_ctl.mode = sqnf_pkg::CELL_SWAP;
            k_in          = k_ff + ONE;
            if (k_ff == LAST) begin
               state_in = sqnf_pkg::ST_DONE;
            end
         end

         sqnf_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_popped_in = res_popped_ff;
               rsp_match_in  = (op_ff == sqnf_pkg::OP_COUNT) ?
                               sqnf_pkg::COUNT_W'(acc_ff) : '0;
               rsp_status_in = res_status_ff;
               rsp_fill_in   = sqnf_pkg::COUNT_W'(cnt_ff);
               state_in      = sqnf_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = sqnf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sqnf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      res_status_ff <= res_status_in;
      val_ff        <= val_in;
      hold_ff       <= hold_in;
      res_popped_ff <= res_popped_in;
      k_ff          <= k_in;
      acc_ff        <= acc_in;
      done_ins_ff   <= done_ins_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_match_ff  <= rsp_match_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = rsp_popped_ff;
   assign rsp_match_count  = rsp_match_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_fill_level   = rsp_fill_ff;

endmodule

// File: rtl/signed_queue_with_negative_filter_top.sv
// ----------------------------------------------------------------------------
// signed_queue_with_negative_filter_top
// Bounded queue of signed words held in a chain of cells, with insert before
// the first negative word, negative removal and match counting.
// ----------------------------------------------------------------------------
// One request word is taken at a time and gives one response word. Dequeue,
// a push into a full queue and an unknown op go from accept straight to the
// response state. Enqueue, insert and count first rotate the whole chain
// once through the sequencer, one word a cycle. Remove negatives runs one
// rotation that marks the words, then QUEUE_DEPTH odd-even exchange rounds
// along the chain. A new request is taken the cycle after the response is
// formed, even while that response still waits on rsp_stall.
module signed_queue_with_negative_filter_top #(
   parameter int QUEUE_DEPTH = sqnf_pkg::QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [sqnf_pkg::OP_W-1:0]           req_op,
   input  logic signed [sqnf_pkg::WORD_W-1:0]  req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [sqnf_pkg::WORD_W-1:0]  rsp_popped_value,
   output logic [sqnf_pkg::COUNT_W-1:0]        rsp_match_count,
   output logic [sqnf_pkg::STATUS_W-1:0]       rsp_status,
   output logic [sqnf_pkg::COUNT_W-1:0]        rsp_fill_level
);

   sqnf_pkg::entry_type    cell_q [QUEUE_DEPTH];
   sqnf_pkg::entry_type    feed;
   sqnf_pkg::cell_ctl_type cell_ctl;

   sqnf_ctrl #(
      .DEPTH (QUEUE_DEPTH)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_popped_value (rsp_popped_value),
      .rsp_match_count  (rsp_match_count),
      .rsp_status       (rsp_status),
      .rsp_fill_level   (rsp_fill_level),
      .head             (cell_q[0]),
      .feed             (feed),
      .cell_ctl         (cell_ctl)
   );

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      sqnf_pkg::entry_type left_w;
      sqnf_pkg::entry_type right_w;

      if (i == 0) begin : g_first
         assign left_w = cell_q[i];
      end else begin : g_mid_left
         assign left_w = cell_q[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_w = feed;
      end else begin : g_mid_right
         assign right_w = cell_q[i+1];
      end

      sqnf_cell #(
         .DEPTH      (QUEUE_DEPTH),
         .CELL_INDEX (i)
      ) u_cell (
         .clock (clock),
         .ctl   (cell_ctl),
         .left  (left_w),
         .right (right_w),
         .entry (cell_q[i])
      );
   end

endmodule
